// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLS_DEF        = 80;
  localparam int ROWS_DEF        = 25;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = 16;
  localparam int ADDR_IN_W  = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  // wide enough for the largest store (128 x 64 cells)
  localparam int CMD_ADDR_W = 13;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd7;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [CMD_ADDR_W-1:0] addr;
    logic [CHAR_W-1:0]     ch;
    logic                  scroll;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [1:0]                   action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic [tcw_pkg::ADDR_IN_W-1:0] cell_address_i,
  output tcw_pkg::cmd_t                     cmd_o
);
  import tcw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CELLS = ROWS * COLS;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          scroll;
  op_e           op;
  logic [CMD_ADDR_W-1:0] addr;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    scroll = 1'b0;
    op     = OP_MOVE;
    addr   = '0;
    unique case (action_e'(action_i))
      ACT_PUT: begin
        if (char_code_i == NEWLINE_CODE) begin
          col_d = '0;
          if (row_q == RW'(ROWS - 1)) begin
            scroll = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          op   = OP_WRITE;
          addr = CMD_ADDR_W'(row_q) * CMD_ADDR_W'(COLS) + CMD_ADDR_W'(col_q);
          if (col_q == CW'(COLS - 1)) begin
            col_d = '0;
            if (row_q == RW'(ROWS - 1)) begin
              scroll = 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (32'(cell_address_i) < CELLS) begin
          op   = OP_READ;
          addr = CMD_ADDR_W'(cell_address_i);
        end
      end
      ACT_CLEAR: begin
        op    = OP_CLEAR;
        row_d = '0;
        col_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd_o = '{op: op, addr: addr, ch: char_code_i, scroll: scroll,
                   row: ROW_W'(row_d), col: COL_W'(col_d)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (32'(row_q) < ROWS) && (32'(col_q) < COLS))
    else $error("cursor left the screen");

endmodule

`default_nettype wire

// ===== hdl/tcw_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_cmd_fifo #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import tcw_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [tcw_pkg::COLOR_W-1:0] color_i,
  input  tcw_pkg::cmd_t                   cmd_i,
  input  wire logic                       cmd_empty_i,
  output logic                            cmd_pop_o,
  output tcw_pkg::res_t                   res_o,
  output logic                            empty_o,
  input  wire logic                       pop_i
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int LAST  = CELLS - COLS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  cmd_t              cur_q, cur_d;
  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  res_t              res_q, res_new;
  logic              out_valid_q, res_load, out_free;

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_load  = 1'b0;
    res_new   = '{value: '0, row: cur_q.row, col: cur_q.col, scrolled: cur_q.scroll};
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && out_free) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          res_new   = '{value: '0, row: cmd_i.row, col: cmd_i.col, scrolled: cmd_i.scroll};
          unique case (cmd_i.op)
            OP_WRITE, OP_MOVE: begin
              if (cmd_i.op == OP_WRITE) begin
                mem_we    = 1'b1;
                mem_waddr = cmd_i.addr[AW-1:0];
                mem_wdata = {color_i, cmd_i.ch};
              end
              if (cmd_i.scroll) begin
                state_d = S_COPY;
                cnt_d   = '0;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = cmd_i.addr[AW-1:0];
              state_d   = S_EMIT;
            end
            OP_CLEAR: begin
              state_d = S_FILL;
              cnt_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        // read runs one cell ahead of the write-back
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q - 1'b1;
          mem_wdata = rdata_q;
        end
        if (cnt_q == AW'(LAST)) begin
          state_d = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q + AW'(COLS);
          cnt_d     = cnt_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {color_i, BLANK_CODE};
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          if (cur_q.op == OP_READ) begin
            res_new.value = rdata_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (res_load) begin
      res_q <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o   = res_q;
  assign empty_o = !out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || pop_i))
    else $error("result overwritten before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("cell write out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && cur_q.op == OP_READ) |->
      ($past(mem_re) || $past(state_q == S_EMIT)))
    else $error("read data not held for emit");

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A put or newline without scroll goes through the command queue into the result
// register; a read also passes the cell memory read register and the emit state.
// Scroll (row copy then blank row), clear (all cells blank) and read stall the queue.
// Throughput: one put per cycle (single cell write port) while results are popped.
// Reset: cursor home, color 7, queues empty; the cell store is undefined until a clear.

module text_console_writer #(
  parameter int COLS        = tcw_pkg::COLS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [tcw_pkg::ADDR_IN_W-1:0] cell_address_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [tcw_pkg::CELL_W-1:0]         cell_value_o,
  output logic [tcw_pkg::ROW_W-1:0]          cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]          cursor_column_o,
  output logic                               scrolled_o,
  input  wire logic                          text_color_we_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   text_color_i
);
  import tcw_pkg::*;

  logic               accept;
  cmd_t               front_cmd, queue_cmd;
  logic               queue_empty, queue_pop;
  res_t               res;
  logic [COLOR_W-1:0] color_q;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (text_color_we_i) begin
      color_q <= text_color_i;
    end
  end

  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action_i),
    .char_code_i    (char_code_i),
    .cell_address_i (cell_address_i),
    .cmd_o          (front_cmd)
  );

  tcw_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .cmd_o   (queue_cmd),
    .empty_o (queue_empty)
  );

  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .color_i     (color_q),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (queue_empty),
    .cmd_pop_o   (queue_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign cell_value_o    = res.value;
  assign cursor_row_o    = res.row;
  assign cursor_column_o = res.col;
  assign scrolled_o      = res.scrolled;

endmodule

`default_nettype wire
